/* rtl/core/gvw_pkg.sv */
// gvw_pkg: shared types, constants and helpers of the grid ray voxel walker
// used by every module of the walker, no dependencies
package gvw_pkg;

    localparam int CW            = 32;   // coordinate and time width
    localparam int BW            = 43;   // box bound width
    localparam int PW            = 64;   // product and dividend width
    localparam int AXW           = 9;    // cell index width per axis
    localparam int NW            = 10;   // cell count width per axis
    localparam int MAX_CELLS     = 512;
    localparam int DIV_STEPS     = 64;
    localparam int DCW           = $clog2(DIV_STEPS);

    localparam logic signed [CW-1:0] TIME_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] TIME_LO = {1'b1, {(CW-1){1'b0}}};

    localparam logic [1:0] STAT_CELL = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_END  = 2'd2;

    localparam logic OPER_START   = 1'b0;
    localparam logic OPER_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        REG_GMIN_X = 3'd0,
        REG_GMIN_Y = 3'd1,
        REG_GMIN_Z = 3'd2,
        REG_CSZ_X  = 3'd3,
        REG_CSZ_Y  = 3'd4,
        REG_CSZ_Z  = 3'd5,
        REG_DIMS   = 3'd6
    } t_reg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_BMUL, ST_BADD, ST_SLAB, ST_W_T0, ST_W_T1, ST_MERGE,
        ST_DECIDE, ST_EMUL, ST_ECLAMP, ST_CGO, ST_W_CELL, ST_NMUL, ST_NGO,
        ST_W_NCT, ST_W_INT, ST_FIN, ST_IDX1, ST_IDX2, ST_ADV, ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_BMUL, OP_BADD, OP_SLAB, OP_ST_T0, OP_ST_T1,
        OP_MERGE, OP_DECIDE, OP_EMUL, OP_ECLAMP, OP_ST_CELL, OP_NMUL,
        OP_ST_NCT, OP_ST_INT, OP_FIN
    } t_op;

    typedef enum logic [2:0] {
        DS_T0, DS_T1, DS_CELL, DS_NCT, DS_INT
    } t_dsel;

    typedef struct packed {
        t_op        op;
        logic       idx1;
        logic       idx2;
        logic       adv;
        logic       emit;
        logic [1:0] ax;
        logic       div_go;
        t_dsel      dsel;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic d_zero;
        logic miss;
        logic in_box;
        logic adv_ok;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic                 operation;
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] ray_t_min;
        logic signed [CW-1:0] ray_t_max;
    } t_req;

    typedef struct packed {
        logic [AXW-1:0] cell_x;
        logic [AXW-1:0] cell_y;
        logic [AXW-1:0] cell_z;
        logic [26:0]    cell_index;
        logic [1:0]     status;
    } t_rsp;

    function automatic logic signed [CW-1:0] sat32(input logic signed [PW-1:0] v);
        if (v > PW'(TIME_HI)) begin
            return TIME_HI;
        end else if (v < PW'(TIME_LO)) begin
            return TIME_LO;
        end
        return v[CW-1:0];
    endfunction

    // cell count of one axis, field plus one, capped
    function automatic logic [NW-1:0] ncells(input logic [26:0] dims, input logic [1:0] ax);
        logic [AXW-1:0] f;
        logic [NW-1:0]  n;
        unique case (ax)
            2'd0:    f = dims[8:0];
            2'd1:    f = dims[17:9];
            default: f = dims[26:18];
        endcase
        n = NW'(f) + NW'(1);
        return (n > NW'(MAX_CELLS)) ? NW'(MAX_CELLS) : n;
    endfunction

    function automatic logic [30:0] csize(input logic [30:0] cs);
        return (cs == 31'd0) ? 31'd1 : cs;
    endfunction

endpackage

/* rtl/core/gvw_in_if.sv */
// gvw_in_if: request channel of the walker, valid/ready plus item fields
// no dependencies
interface gvw_in_if;
    logic              valid;
    logic              ready;
    logic              operation;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] ray_t_min;
    logic signed [31:0] ray_t_max;

    modport source (output valid, operation, origin_x, origin_y, origin_z,
                    dir_x, dir_y, dir_z, ray_t_min, ray_t_max, input ready);
    modport sink (input valid, operation, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, ray_t_min, ray_t_max, output ready);
endinterface

/* rtl/core/gvw_out_if.sv */
// gvw_out_if: result channel of the walker, valid/ready plus item fields
// no dependencies
interface gvw_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  cell_x;
    logic [8:0]  cell_y;
    logic [8:0]  cell_z;
    logic [26:0] cell_index;
    logic [1:0]  status;

    modport source (output valid, cell_x, cell_y, cell_z, cell_index, status,
                    input ready);
    modport sink (input valid, cell_x, cell_y, cell_z, cell_index, status,
                  output ready);
endinterface

/* rtl/core/gvw_div.sv */
// gvw_div: serial signed divider, one quotient bit per cycle, truncating
// depends on gvw_pkg
module gvw_div
    import gvw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [PW-1:0] i_num,
    input  logic signed [32:0]   i_den,
    output logic                 o_done,
    output logic signed [PW-1:0] o_quot
);

    logic           r_busy;
    logic           r_done;
    logic           r_neg;
    logic [DCW-1:0] r_cnt;
    logic [PW-1:0]  r_dvd;
    logic [31:0]    r_dsr;
    logic [31:0]    r_rem;

    logic [32:0]    rem_sh;
    logic           qbit;
    logic [31:0]    rem_nx;
    logic [PW-1:0]  num_mag;
    logic [32:0]    den_mag;

    assign num_mag = i_num[PW-1] ? PW'(-i_num) : PW'(i_num);
    assign den_mag = i_den[32] ? 33'(-i_den) : 33'(i_den);
    assign rem_sh  = {r_rem, r_dvd[PW-1]};
    assign qbit    = rem_sh >= {1'b0, r_dsr};
    assign rem_nx  = qbit ? 32'(rem_sh - {1'b0, r_dsr}) : rem_sh[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[PW-1] ^ i_den[32];
                r_dvd  <= num_mag;
                r_dsr  <= den_mag[31:0];
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= rem_nx;
                r_dvd <= {r_dvd[PW-2:0], qbit};
                r_cnt <= r_cnt + DCW'(1);
                if (r_cnt == DCW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_dvd) : $signed(r_dvd);

endmodule

/* rtl/core/gvw_dp.sv */
// gvw_dp: walker datapath, config registers, ray state, divider and result register
// depends on gvw_pkg and gvw_div
module gvw_dp
    import gvw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    input  t_req          i_req,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output t_rsp          o_rsp
);

    logic signed [CW-1:0]  r_gmin [3];
    logic [30:0]           r_csz [3];
    logic [26:0]           r_dims;

    logic signed [CW-1:0]  r_o [3];
    logic signed [CW-1:0]  r_d [3];
    logic signed [CW-1:0]  r_tmax;
    logic signed [BW-1:0]  r_lo [3];
    logic signed [BW-1:0]  r_hi [3];
    logic signed [BW-1:0]  r_st [3];
    logic signed [PW-1:0]  r_prod;
    logic signed [CW-1:0]  r_t0, r_t1, r_tn, r_tf, r_ts, r_te;
    logic                  r_hit, r_inside;

    logic [AXW-1:0]        r_pos [3];
    logic signed [CW-1:0]  r_nct [3];
    logic signed [CW-1:0]  r_int [3];
    logic signed [1:0]     r_step [3];
    logic signed [CW-1:0]  r_exit;
    logic                  r_active;
    logic [1:0]            r_pend;
    logic [19:0]           r_idxa;
    logic [26:0]           r_index;
    logic                  r_ovalid;
    t_rsp                  r_rsp;

    logic [1:0]            ax;
    logic [NW-1:0]         cnt_ax;
    logic [30:0]           cs_ax;
    logic signed [CW-1:0]  d_ax;
    logic signed [BW-1:0]  o_ext;
    logic                  o_out;

    logic signed [PW-1:0]  div_num;
    logic signed [32:0]    div_den;
    logic                  div_done;
    logic signed [PW-1:0]  div_q;
    logic signed [CW-1:0]  q_sat;

    logic signed [CW-1:0]  t_lo, t_hi;
    logic [40:0]           bprod;
    logic signed [PW-1:0]  eprod;
    logic signed [49:0]    ent_p;
    logic signed [49:0]    lo50, hi50;
    logic [NW-1:0]         cc;
    logic [9:0]            cell_c;

    logic [1:0]            asel;
    logic signed [10:0]    advc;
    logic                  adv_fail;
    logic [NW-1:0]         cnt_sel;

    assign ax     = i_cmd.ax;
    assign cnt_ax = ncells(r_dims, ax);
    assign cs_ax  = csize(r_csz[ax]);
    assign d_ax   = r_d[ax];
    assign o_ext  = BW'(r_o[ax]);
    assign o_out  = (o_ext < r_lo[ax]) || (o_ext > r_hi[ax]);

    // divider operand selection
    always_comb begin
        div_num = '0;
        div_den = 33'(d_ax);
        unique case (i_cmd.dsel)
            DS_T0: div_num = (PW'(r_lo[ax]) - PW'(r_o[ax])) <<< 16;
            DS_T1: div_num = (PW'(r_hi[ax]) - PW'(r_o[ax])) <<< 16;
            DS_CELL: begin
                div_num = PW'(r_st[ax]) - PW'(r_lo[ax]);
                div_den = $signed({2'b00, cs_ax});
            end
            DS_NCT: div_num = (r_prod + PW'(r_lo[ax]) - PW'(r_st[ax])) <<< 16;
            default: begin
                div_num = $signed(PW'(cs_ax)) <<< 16;
                div_den = d_ax[CW-1] ? -33'(d_ax) : 33'(d_ax);
            end
        endcase
    end

    gvw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign q_sat  = sat32(div_q);
    assign t_lo   = (r_t0 > r_t1) ? r_t1 : r_t0;
    assign t_hi   = (r_t0 > r_t1) ? r_t0 : r_t1;
    assign bprod  = 41'(cnt_ax) * 41'(cs_ax);
    assign eprod  = d_ax * r_ts;
    assign lo50   = 50'(r_lo[ax]);
    assign hi50   = 50'(r_hi[ax]);
    assign ent_p  = 50'(r_o[ax]) + 50'(r_prod >>> 16);
    assign cc     = (d_ax > 0) ? NW'(r_pos[ax]) + NW'(1) : NW'(r_pos[ax]);
    assign cell_c = (div_q > PW'(cnt_ax - NW'(1))) ? cnt_ax - NW'(1) : div_q[NW-1:0];

    // advance picks the earliest crossing, ties y then z then x
    always_comb begin
        if (r_nct[0] < r_nct[1] && r_nct[0] < r_nct[2]) begin
            asel = 2'd0;
        end else if (r_nct[2] < r_nct[1]) begin
            asel = 2'd2;
        end else begin
            asel = 2'd1;
        end
    end

    assign cnt_sel  = ncells(r_dims, asel);
    assign advc     = $signed({2'b00, r_pos[asel]}) + 11'(r_step[asel]);
    assign adv_fail = (r_step[asel] == 2'sd0) || (r_exit < r_nct[asel]) ||
                      (advc < 11'sd0) || (advc >= $signed({1'b0, cnt_sel}));

    assign o_stat.div_done = div_done;
    assign o_stat.d_zero   = (d_ax == '0);
    assign o_stat.miss     = !r_hit || (r_tn > r_tf);
    assign o_stat.in_box   = r_inside;
    assign o_stat.adv_ok   = r_active && !adv_fail;
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_gmin[i] <= '0;
                r_csz[i]  <= 31'd65536;
                r_pos[i]  <= '0;
                r_nct[i]  <= '0;
                r_int[i]  <= '0;
                r_step[i] <= '0;
            end
            r_dims   <= '0;
            r_exit   <= '0;
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GMIN_X: r_gmin[0] <= $signed(i_cfg_wdata);
                    REG_GMIN_Y: r_gmin[1] <= $signed(i_cfg_wdata);
                    REG_GMIN_Z: r_gmin[2] <= $signed(i_cfg_wdata);
                    REG_CSZ_X:  r_csz[0]  <= i_cfg_wdata[30:0];
                    REG_CSZ_Y:  r_csz[1]  <= i_cfg_wdata[30:0];
                    REG_CSZ_Z:  r_csz[2]  <= i_cfg_wdata[30:0];
                    REG_DIMS:   r_dims    <= i_cfg_wdata[26:0];
                    default: ;
                endcase
            end

            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_o[0]   <= i_req.origin_x;
                    r_o[1]   <= i_req.origin_y;
                    r_o[2]   <= i_req.origin_z;
                    r_d[0]   <= i_req.dir_x;
                    r_d[1]   <= i_req.dir_y;
                    r_d[2]   <= i_req.dir_z;
                    r_tmax   <= i_req.ray_t_max;
                    r_tn     <= i_req.ray_t_min;
                    r_tf     <= i_req.ray_t_max;
                    r_hit    <= 1'b1;
                    r_inside <= 1'b1;
                end
                OP_BMUL: r_prod <= $signed(PW'(bprod));
                OP_BADD: begin
                    r_lo[ax] <= BW'(r_gmin[ax]);
                    r_hi[ax] <= BW'(r_gmin[ax]) + r_prod[BW-1:0];
                end
                OP_SLAB: begin
                    if (o_out) begin
                        r_inside <= 1'b0;
                        if (d_ax == '0) begin
                            r_hit <= 1'b0;
                        end
                    end
                end
                OP_ST_T0: r_t0 <= q_sat;
                OP_ST_T1: r_t1 <= q_sat;
                OP_MERGE: begin
                    if (t_lo > r_tn) begin
                        r_tn <= t_lo;
                    end
                    if (t_hi < r_tf) begin
                        r_tf <= t_hi;
                    end
                end
                OP_DECIDE: begin
                    if (!r_hit || (r_tn > r_tf)) begin
                        r_active <= 1'b0;
                        r_pend   <= STAT_MISS;
                    end else if (r_inside) begin
                        r_ts <= '0;
                        r_te <= r_tmax;
                        for (int i = 0; i < 3; i++) begin
                            r_st[i] <= BW'(r_o[i]);
                        end
                    end else begin
                        r_ts <= r_tn;
                        r_te <= (r_tf < r_tmax) ? r_tf : r_tmax;
                    end
                end
                OP_EMUL: r_prod <= eprod;
                OP_ECLAMP: begin
                    // entry point pulled back onto the box
                    if (ent_p < lo50) begin
                        r_st[ax] <= r_lo[ax];
                    end else if (ent_p > hi50) begin
                        r_st[ax] <= r_hi[ax];
                    end else begin
                        r_st[ax] <= ent_p[BW-1:0];
                    end
                end
                OP_ST_CELL: begin
                    r_pos[ax] <= cell_c[AXW-1:0];
                    if (d_ax == '0) begin
                        r_nct[ax]  <= TIME_HI;
                        r_int[ax]  <= '0;
                        r_step[ax] <= 2'sd0;
                    end
                end
                OP_NMUL: r_prod <= $signed(PW'(41'(cc) * 41'(cs_ax)));
                OP_ST_NCT: r_nct[ax] <= sat32(PW'(r_ts) + PW'(q_sat));
                OP_ST_INT: begin
                    r_int[ax]  <= q_sat;
                    r_step[ax] <= (d_ax > 0) ? 2'sd1 : -2'sd1;
                end
                OP_FIN: begin
                    r_exit   <= r_te;
                    r_active <= 1'b1;
                    r_pend   <= STAT_CELL;
                end
                default: ;
            endcase

            if (i_cmd.adv) begin
                if (!r_active || adv_fail) begin
                    r_active <= 1'b0;
                    r_pend   <= STAT_END;
                end else begin
                    r_pos[asel] <= advc[AXW-1:0];
                    r_nct[asel] <= sat32(PW'(r_nct[asel]) + PW'(r_int[asel]));
                    r_pend      <= STAT_CELL;
                end
            end

            // linear index as (z*ny + y)*nx + x, with the inner term registered in r_idxa first
            if (i_cmd.idx1) begin
                r_idxa <= 20'(r_pos[2]) * 20'(ncells(r_dims, 2'd1)) + 20'(r_pos[1]);
            end
            if (i_cmd.idx2) begin
                r_index <= 27'(30'(r_idxa) * 30'(ncells(r_dims, 2'd0)) + 30'(r_pos[0]));
            end

            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end

        if (i_cmd.emit) begin
            if (r_pend == STAT_CELL) begin
                r_rsp.cell_x     <= r_pos[0];
                r_rsp.cell_y     <= r_pos[1];
                r_rsp.cell_z     <= r_pos[2];
                r_rsp.cell_index <= r_index;
            end else begin
                r_rsp.cell_x     <= '0;
                r_rsp.cell_y     <= '0;
                r_rsp.cell_z     <= '0;
                r_rsp.cell_index <= '0;
            end
            r_rsp.status <= r_pend;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_rsp       = r_rsp;

endmodule

/* rtl/core/gvw_ctrl.sv */
// gvw_ctrl: walker sequencer, steps the datapath through ray setup and advance
// depends on gvw_pkg
module gvw_ctrl
    import gvw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_oper,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_ax, n_ax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ax    <= '0;
        end else begin
            r_state <= n_state;
            r_ax    <= n_ax;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ax         = r_ax;
        o_in_ready   = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.idx1   = 1'b0;
        o_cmd.idx2   = 1'b0;
        o_cmd.adv    = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.ax     = r_ax;
        o_cmd.div_go = 1'b0;
        o_cmd.dsel   = DS_T0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_oper == OPER_START) begin
                        o_cmd.op = OP_LOAD;
                        n_ax     = 2'd0;
                        n_state  = ST_BMUL;
                    end else begin
                        n_state = ST_ADV;
                    end
                end
            end
            ST_BMUL: begin
                o_cmd.op = OP_BMUL;
                n_state  = ST_BADD;
            end
            ST_BADD: begin
                o_cmd.op = OP_BADD;
                n_state  = ST_SLAB;
            end
            ST_SLAB: begin
                o_cmd.op = OP_SLAB;
                if (i_stat.d_zero) begin
                    n_ax    = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    n_state = (r_ax == 2'd2) ? ST_DECIDE : ST_BMUL;
                end else begin
                    o_cmd.div_go = 1'b1;
                    o_cmd.dsel   = DS_T0;
                    n_state      = ST_W_T0;
                end
            end
            ST_W_T0: begin
                if (i_stat.div_done) begin
                    o_cmd.op     = OP_ST_T0;
                    o_cmd.div_go = 1'b1;
                    o_cmd.dsel   = DS_T1;
                    n_state      = ST_W_T1;
                end
            end
            ST_W_T1: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_ST_T1;
                    n_state  = ST_MERGE;
                end
            end
            ST_MERGE: begin
                o_cmd.op = OP_MERGE;
                n_ax     = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                n_state  = (r_ax == 2'd2) ? ST_DECIDE : ST_BMUL;
            end
            ST_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_ax     = 2'd0;
                priority if (i_stat.miss) begin
                    n_state = ST_EMIT;
                end else if (i_stat.in_box) begin
                    n_state = ST_CGO;
                end else begin
                    n_state = ST_EMUL;
                end
            end
            ST_EMUL: begin
                o_cmd.op = OP_EMUL;
                n_state  = ST_ECLAMP;
            end
            ST_ECLAMP: begin
                o_cmd.op = OP_ECLAMP;
                n_ax     = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                n_state  = (r_ax == 2'd2) ? ST_CGO : ST_EMUL;
            end
            ST_CGO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.dsel   = DS_CELL;
                n_state      = ST_W_CELL;
            end
            ST_W_CELL: begin
                o_cmd.dsel = DS_CELL;
                if (i_stat.div_done) begin
                    o_cmd.op = OP_ST_CELL;
                    if (i_stat.d_zero) begin
                        n_ax    = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                        n_state = (r_ax == 2'd2) ? ST_FIN : ST_CGO;
                    end else begin
                        n_state = ST_NMUL;
                    end
                end
            end
            ST_NMUL: begin
                o_cmd.op = OP_NMUL;
                n_state  = ST_NGO;
            end
            ST_NGO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.dsel   = DS_NCT;
                n_state      = ST_W_NCT;
            end
            ST_W_NCT: begin
                if (i_stat.div_done) begin
                    o_cmd.op     = OP_ST_NCT;
                    o_cmd.div_go = 1'b1;
                    o_cmd.dsel   = DS_INT;
                    n_state      = ST_W_INT;
                end
            end
            ST_W_INT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_ST_INT;
                    n_ax     = (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    n_state  = (r_ax == 2'd2) ? ST_FIN : ST_CGO;
                end
            end
            ST_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = ST_IDX1;
            end
            ST_IDX1: begin
                o_cmd.idx1 = 1'b1;
                n_state    = ST_IDX2;
            end
            ST_IDX2: begin
                o_cmd.idx2 = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = i_stat.adv_ok ? ST_IDX1 : ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* rtl/core/grid_ray_voxel_walker_top.sv */
// grid_ray_voxel_walker_top: 3D DDA voxel walker, sequencer plus datapath
// depends on gvw_pkg, gvw_in_if, gvw_out_if, gvw_ctrl, gvw_dp
//
//  port      dir  handshake       carries
//  i_req     in   valid/ready     operation, origin, direction, t range
//  o_rsp     out  valid/ready     cell x/y/z, linear cell index, status
//  i_cfg_*   in   write enable    grid corner, cell sizes, grid dims
//
// a start item runs up to fifteen divisions through the one serial divider, plus
// multiply and clamp steps per axis
// an advance item steps one axis, then forms the index via r_idxa and r_index
// reset is synchronous, active low; it resets the walk state and the config registers
// a result waits in the output register; the next item is taken meanwhile
module grid_ray_voxel_walker_top
    import gvw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gvw_in_if.sink      i_req,
    gvw_out_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;
    t_req  req;
    t_rsp  rsp;
    logic  out_valid;

    assign req.operation = i_req.operation;
    assign req.origin_x  = i_req.origin_x;
    assign req.origin_y  = i_req.origin_y;
    assign req.origin_z  = i_req.origin_z;
    assign req.dir_x     = i_req.dir_x;
    assign req.dir_y     = i_req.dir_y;
    assign req.dir_z     = i_req.dir_z;
    assign req.ray_t_min = i_req.ray_t_min;
    assign req.ray_t_max = i_req.ray_t_max;

    gvw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_oper  (i_req.operation),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gvw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_rsp       (rsp)
    );

    assign o_rsp.valid      = out_valid;
    assign o_rsp.cell_x     = rsp.cell_x;
    assign o_rsp.cell_y     = rsp.cell_y;
    assign o_rsp.cell_z     = rsp.cell_z;
    assign o_rsp.cell_index = rsp.cell_index;
    assign o_rsp.status     = rsp.status;

endmodule

/* tb/grid_ray_voxel_walker_top_test.sv */
// grid_ray_voxel_walker_top_test: random and directed check of the 3D DDA voxel walker
// depends on gvw_pkg, gvw_in_if, gvw_out_if and grid_ray_voxel_walker_top
// an in-bench walker model predicts every result; valid/ready traffic with random gaps
class voxel_walk_predictor;
    longint gmin[3];
    longint csz[3];
    logic [26:0] dims;
    longint cell_pos[3];
    longint next_cross[3];
    longint cross_step[3];
    int     step_dir[3];
    longint exit_t;
    bit     walking;
    gvw_pkg::t_rsp expected_cells[$];
    int     errors;

    function new();
        for (int i = 0; i < 3; i++) begin
            gmin[i] = 0;
            csz[i] = 65536;
            cell_pos[i] = 0;
            next_cross[i] = 0;
            cross_step[i] = 0;
            step_dir[i] = 0;
        end
        dims = '0;
        exit_t = 0;
        walking = 0;
        errors = 0;
    endfunction

    function void set_reg(gvw_pkg::t_reg idx, logic [31:0] v);
        case (idx)
            gvw_pkg::REG_GMIN_X: gmin[0] = longint'($signed(v));
            gvw_pkg::REG_GMIN_Y: gmin[1] = longint'($signed(v));
            gvw_pkg::REG_GMIN_Z: gmin[2] = longint'($signed(v));
            gvw_pkg::REG_CSZ_X:  csz[0] = longint'(v[30:0]);
            gvw_pkg::REG_CSZ_Y:  csz[1] = longint'(v[30:0]);
            gvw_pkg::REG_CSZ_Z:  csz[2] = longint'(v[30:0]);
            gvw_pkg::REG_DIMS:   dims = v[26:0];
            default: ;
        endcase
    endfunction

    function longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint qdiv(longint num, longint den);
        return sat((num * 65536) / den);
    endfunction

    function longint floor_q(longint x);
        return (x >= 0) ? x / 65536 : -((-x + 65535) / 65536);
    endfunction

    function longint n_of(int i);
        longint n;
        n = longint'((dims >> (9 * i)) & 27'h1FF) + 1;
        return (n > 512) ? 512 : n;
    endfunction

    function longint cs_of(int i);
        return (csz[i] < 1) ? 1 : csz[i];
    endfunction

    function gvw_pkg::t_rsp make_cell(logic [1:0] st);
        gvw_pkg::t_rsp r;
        longint x, y, z;
        r = '0;
        r.status = st;
        if (st == gvw_pkg::STAT_CELL) begin
            x = cell_pos[0] & 'h1FF;
            y = cell_pos[1] & 'h1FF;
            z = cell_pos[2] & 'h1FF;
            r.cell_x = x[8:0];
            r.cell_y = y[8:0];
            r.cell_z = z[8:0];
            r.cell_index = 27'(z * n_of(1) * n_of(0) + y * n_of(0) + x);
        end
        return r;
    endfunction

    function gvw_pkg::t_rsp start_walk(gvw_pkg::t_req q);
        longint o[3], d[3], lo[3], hi[3], st[3];
        longint tn, tf, ts, te, t0, t1, tmp, p, c, cs;
        bit hit, in_box;
        tn = longint'(q.ray_t_min);
        tf = longint'(q.ray_t_max);
        hit = 1;
        in_box = 1;
        o[0] = q.origin_x; o[1] = q.origin_y; o[2] = q.origin_z;
        d[0] = q.dir_x;    d[1] = q.dir_y;    d[2] = q.dir_z;
        for (int i = 0; i < 3; i++) begin
            lo[i] = gmin[i];
            hi[i] = gmin[i] + n_of(i) * cs_of(i);
            if (o[i] < lo[i] || o[i] > hi[i]) in_box = 0;
            if (d[i] == 0) begin
                if (o[i] < lo[i] || o[i] > hi[i]) hit = 0;
            end else begin
                t0 = qdiv(lo[i] - o[i], d[i]);
                t1 = qdiv(hi[i] - o[i], d[i]);
                if (t0 > t1) begin
                    tmp = t0; t0 = t1; t1 = tmp;
                end
                if (t0 > tn) tn = t0;
                if (t1 < tf) tf = t1;
            end
        end
        if (tn > tf) hit = 0;
        if (!hit) begin
            walking = 0;
            return make_cell(gvw_pkg::STAT_MISS);
        end
        if (in_box) begin
            ts = 0;
            te = longint'(q.ray_t_max);
            for (int i = 0; i < 3; i++) st[i] = o[i];
        end else begin
            ts = tn;
            te = (tf < longint'(q.ray_t_max)) ? tf : longint'(q.ray_t_max);
            for (int i = 0; i < 3; i++) begin
                p = o[i] + floor_q(d[i] * ts);
                st[i] = (p < lo[i]) ? lo[i] : ((p > hi[i]) ? hi[i] : p);
            end
        end
        for (int i = 0; i < 3; i++) begin
            cs = cs_of(i);
            c = (st[i] - lo[i]) / cs;
            if (c > n_of(i) - 1) c = n_of(i) - 1;
            cell_pos[i] = c;
            if (d[i] > 0) begin
                next_cross[i] = sat(ts + qdiv((c + 1) * cs + lo[i] - st[i], d[i]));
                cross_step[i] = qdiv(cs, d[i]);
                step_dir[i] = 1;
            end else if (d[i] < 0) begin
                next_cross[i] = sat(ts + qdiv(c * cs + lo[i] - st[i], d[i]));
                cross_step[i] = qdiv(cs, -d[i]);
                step_dir[i] = -1;
            end else begin
                next_cross[i] = 64'sd2147483647;
                cross_step[i] = 0;
                step_dir[i] = 0;
            end
        end
        exit_t = te;
        walking = 1;
        return make_cell(gvw_pkg::STAT_CELL);
    endfunction

    function gvw_pkg::t_rsp step_walk();
        int a;
        longint c;
        if (!walking) return make_cell(gvw_pkg::STAT_END);
        // ties go to y, then z, then x
        if (next_cross[0] < next_cross[1] && next_cross[0] < next_cross[2]) a = 0;
        else if (next_cross[2] < next_cross[1]) a = 2;
        else a = 1;
        c = cell_pos[a] + step_dir[a];
        if (step_dir[a] == 0 || exit_t < next_cross[a] || c < 0 || c >= n_of(a)) begin
            walking = 0;
            return make_cell(gvw_pkg::STAT_END);
        end
        cell_pos[a] = c;
        next_cross[a] = sat(next_cross[a] + cross_step[a]);
        return make_cell(gvw_pkg::STAT_CELL);
    endfunction

    function void note_request(gvw_pkg::t_req q);
        if (q.operation == gvw_pkg::OPER_START) expected_cells.push_back(start_walk(q));
        else expected_cells.push_back(step_walk());
    endfunction

    function void check_cell(gvw_pkg::t_rsp got);
        gvw_pkg::t_rsp want;
        if (expected_cells.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        want = expected_cells.pop_front();
        if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
            got.cell_z !== want.cell_z || got.cell_index !== want.cell_index ||
            got.status !== want.status) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

module grid_ray_voxel_walker_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gvw_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    gvw_in_if  req();
    gvw_out_if rsp();

    grid_ray_voxel_walker_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    voxel_walk_predictor walker = new();

    bit sender_idles;
    bit sink_stalls;
    int idle_pct;
    bit hold_kick;
    int hold_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_kick && hold_left == 0) hold_left <= 3000;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (rsp.valid && rsp.ready) begin
            walker.check_cell('{rsp.cell_x, rsp.cell_y, rsp.cell_z, rsp.cell_index,
                                rsp.status});
        end
        rsp.ready <= (hold_left <= 1) && !hold_kick &&
                     (!sink_stalls || $urandom_range(99) >= idle_pct);
    end

    initial begin
        #100ms;
        $display("grid_ray_voxel_walker_top verification failed");
        $finish;
    end

    task automatic cfg_write(t_reg idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        walker.set_reg(idx, v);
    endtask

    task automatic wait_drained();
        while (walker.expected_cells.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic apply_setting(int k);
        case (k)
            0: begin
                cfg_write(REG_GMIN_X, 0); cfg_write(REG_GMIN_Y, 0); cfg_write(REG_GMIN_Z, 0);
                cfg_write(REG_CSZ_X, 65536); cfg_write(REG_CSZ_Y, 65536);
                cfg_write(REG_CSZ_Z, 65536); cfg_write(REG_DIMS, 0);
            end
            1: begin
                cfg_write(REG_GMIN_X, -(4 << 16)); cfg_write(REG_GMIN_Y, -(4 << 16));
                cfg_write(REG_GMIN_Z, -(4 << 16));
                cfg_write(REG_CSZ_X, 65536); cfg_write(REG_CSZ_Y, 65536);
                cfg_write(REG_CSZ_Z, 65536);
                cfg_write(REG_DIMS, 7 | (7 << 9) | (7 << 18));
            end
            2: begin
                // extremes: zero size taken as one, widest sizes, all dims bits set
                cfg_write(REG_GMIN_X, 32'h8000_0000); cfg_write(REG_GMIN_Y, 32'h7FFF_FFFF);
                cfg_write(REG_GMIN_Z, $urandom);
                cfg_write(REG_CSZ_X, 0); cfg_write(REG_CSZ_Y, 32'hFFFF_FFFF);
                cfg_write(REG_CSZ_Z, 32'h7FFF_FFFF);
                cfg_write(REG_DIMS, 32'hFFFF_FFFF);
            end
            default: begin
                cfg_write(REG_GMIN_X, $urandom_range(0, 1 << 21) - (1 << 20));
                cfg_write(REG_GMIN_Y, $urandom_range(0, 1 << 21) - (1 << 20));
                cfg_write(REG_GMIN_Z, $urandom_range(0, 1 << 21) - (1 << 20));
                cfg_write(REG_CSZ_X, $urandom_range(1 << 12, 1 << 18));
                cfg_write(REG_CSZ_Y, $urandom_range(1 << 12, 1 << 18));
                cfg_write(REG_CSZ_Z, $urandom_range(1 << 12, 1 << 18));
                cfg_write(REG_DIMS, $urandom_range(0, 31) | ($urandom_range(0, 31) << 9) |
                                    ($urandom_range(0, 31) << 18));
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(t_req q);
        while (sender_idles && $urandom_range(99) < idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.operation <= q.operation;
        req.origin_x <= q.origin_x;
        req.origin_y <= q.origin_y;
        req.origin_z <= q.origin_z;
        req.dir_x <= q.dir_x;
        req.dir_y <= q.dir_y;
        req.dir_z <= q.dir_z;
        req.ray_t_min <= q.ray_t_min;
        req.ray_t_max <= q.ray_t_max;
        do @(posedge i_clk); while (!(req.valid && req.ready));
        walker.note_request(q);
    endtask

    function automatic t_req advance_item();
        t_req q;
        logic [287:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom};
        q = bits[256:0];
        q.operation = OPER_ADVANCE;
        return q;
    endfunction

    function automatic t_req ray_item(
        logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
        logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
        logic [31:0] tmin, logic [31:0] tmax);
        return '{OPER_START, ox, oy, oz, dx, dy, dz, tmin, tmax};
    endfunction

    // origin near the box, small or zero directions, mostly open t range
    function automatic t_req aimed_ray();
        t_req q;
        logic [31:0] o[3], d[3];
        longint span, cs, off;
        for (int i = 0; i < 3; i++) begin
            cs = walker.cs_of(i);
            span = walker.n_of(i) * cs + 2 * cs;
            off = longint'({$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF) % (span + 1);
            o[i] = 32'(walker.gmin[i] - cs + off);
            if ($urandom_range(5) == 0) d[i] = 0;
            else begin
                d[i] = $urandom_range(1, 1 << $urandom_range(8, 20));
                if ($urandom_range(1)) d[i] = -d[i];
            end
        end
        q = ray_item(o[0], o[1], o[2], d[0], d[1], d[2],
                     $urandom_range(3) == 0 ? $urandom_range(0, 1 << 18) - (1 << 17) : 0,
                     $urandom_range(9) < 7 ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 22));
        return q;
    endfunction

    task automatic random_phase(int items);
        int sent;
        int walk_len;
        t_req q;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) == 0) begin
                // fully random item, either operation
                q = advance_item();
                q.operation = 1'($urandom_range(1));
                send(q);
                sent++;
            end else begin
                send(aimed_ray());
                sent++;
                walk_len = $urandom_range(2, 30);
                for (int j = 0; j < walk_len && sent < items; j++) begin
                    send(advance_item());
                    sent++;
                end
            end
        end
        req.valid <= 1'b0;
    endtask

    initial begin
        req.valid = 1'b0;
        req.operation = OPER_START;
        req.origin_x = '0; req.origin_y = '0; req.origin_z = '0;
        req.dir_x = '0; req.dir_y = '0; req.dir_z = '0;
        req.ray_t_min = '0; req.ray_t_max = '0;
        rsp.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_GMIN_X;
        i_cfg_wdata = '0;
        sender_idles = 0;
        sink_stalls = 0;
        idle_pct = 59;
        hold_kick = 0;
        hold_left = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no walk yet, then special rays on an 8x8x8 box
        send(advance_item());
        req.valid <= 1'b0;
        wait_drained();
        apply_setting(1);
        send(ray_item(0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send(advance_item());
        send(advance_item());
        send(ray_item(10 << 16, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send(ray_item(0, 0, 0, 1 << 16, 0, 0, 5 << 16, 1 << 16));
        send(ray_item(-(9 << 16), 1 << 15, 1 << 15, 1 << 16, 1 << 16, 1 << 16,
                      0, 32'h7FFF_FFFF));
        for (int j = 0; j < 5; j++) send(advance_item());
        send(ray_item(3 << 16, 3 << 16, 3 << 16, -(1 << 16), -(1 << 16), -(1 << 16),
                      0, 3 << 16));
        for (int j = 0; j < 6; j++) send(advance_item());
        send(ray_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send(advance_item());
        send(ray_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send(advance_item());
        send(ray_item(4 << 16, 0, 0, 1 << 16, 0, 0, 0, 32'h7FFF_FFFF));
        send(advance_item());
        req.valid <= 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            apply_setting(ph % 4);
            sender_idles = (ph % 4 == 1) || (ph % 4 == 3 && ph < 4);
            sink_stalls = (ph % 4 == 2) || (ph % 4 == 3 && ph < 4);
            idle_pct = 59;
            if (ph == 3) begin
                sender_idles = 1;
                sink_stalls = 1;
                idle_pct = 7;
            end
            if (ph == 4) begin
                hold_kick <= 1'b1;
                @(posedge i_clk);
                hold_kick <= 1'b0;
            end
            random_phase(ph == 3 ? 20 : 245);
        end

        wait_drained();
        repeat (900) @(posedge i_clk);
        if (walker.errors == 0 && walker.expected_cells.size() == 0) begin
            $display("grid_ray_voxel_walker_top verification clean");
        end else begin
            $display("grid_ray_voxel_walker_top verification failed");
        end
        $finish;
    end
endmodule
